// ----- design/edip_pkg.sv -----
// Shared types and constants for the event double-integral pixel engine.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package edip_pkg;

	// Field widths
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 7;
	localparam int ENTRY_W = TIME_W + 2 * CNT_W;
	localparam int INT_W   = 48;
	localparam int OUT_W   = 32;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DVD_W   = 56;
	localparam int DIVC_W  = 6;

	localparam logic [CNT_W-1:0]  COUNT_MAX = 7'd127;
	localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
	localparam logic [15:0]       EXP_C1    = 16'd45551;
	localparam logic [15:0]       EXP_C2    = 16'd14824;
	localparam logic [15:0]       EXP_C3    = 16'd5161;
	localparam logic [DIVC_W-1:0] DIV_LAST  = 6'd55;

	// Configuration register indexes
	localparam logic REG_POS_CONTRAST = 1'b0;
	localparam logic REG_NEG_CONTRAST = 1'b1;

	// Polarity codes; both negative codes count as a darker event
	localparam logic [1:0] POL_SHUTTER = 2'b00;
	localparam logic [1:0] POL_POS     = 2'b01;
	localparam logic [1:0] POL_NEG2    = 2'b10;
	localparam logic [1:0] POL_NEG     = 2'b11;

	typedef enum logic [1:0] {
		OP_OPEN  = 2'd0,
		OP_EVENT = 2'd1,
		OP_BLUR  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ZERO    = 2'd2,
		ST_NOTOPEN = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		MS_LOG  = 3'd0,
		MS_P1   = 3'd1,
		MS_P2   = 3'd2,
		MS_P3   = 3'd3,
		MS_TERM = 3'd4,
		MS_QRY  = 3'd5,
		MS_NUM  = 3'd6
	} mul_sel_t;

	typedef enum logic [1:0] {
		RS_ZERO  = 2'd0,
		RS_SHARP = 2'd1,
		RS_QRY   = 2'd2
	} res_src_t;

	typedef enum logic [1:0] {
		RD_LAST = 2'd0,
		RD_ZERO = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     item_load;
		logic     open;
		logic     shut;
		logic     ram_rd;
		rd_sel_t  rd_sel;
		logic     ent_load;
		logic     idx_clr;
		logic     idx_inc;
		logic     x_load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     split;
		logic     e_load;
		logic     int_add;
		logic     append;
		logic     div_init;
		logic     div_step;
		logic     sharp_div;
		logic     sharp_clr;
		logic     res_load;
		res_src_t res_src;
		stat_t    res_stat;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic full;
		logic int_zero;
		logic exposing;
		logic walk_more;
		logic walk_hit;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/edip_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module edip_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/edip_ctrl.sv -----
// Controller state machine of the pixel engine: sequences each item.
// Depends on edip_pkg; drives cmd_t to the datapath, reads sts_t back.
`default_nettype none

module edip_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire edip_pkg::sts_t sts,
	output edip_pkg::cmd_t      cmd
);
	import edip_pkg::*;

	typedef enum logic [22:0] {
		S_IDLE   = 23'd1 << 0,
		S_DECODE = 23'd1 << 1,
		S_OPEN   = 23'd1 << 2,
		S_LLD    = 23'd1 << 3,
		S_EXX    = 23'd1 << 4,
		S_EXLOG  = 23'd1 << 5,
		S_EXSPL  = 23'd1 << 6,
		S_EXP1   = 23'd1 << 7,
		S_EXP2   = 23'd1 << 8,
		S_EXP3   = 23'd1 << 9,
		S_EXFIN  = 23'd1 << 10,
		S_TERM   = 23'd1 << 11,
		S_ADD    = 23'd1 << 12,
		S_APPEND = 23'd1 << 13,
		S_NUM    = 23'd1 << 14,
		S_DIVI   = 23'd1 << 15,
		S_DIV    = 23'd1 << 16,
		S_DIVFIN = 23'd1 << 17,
		S_WLD0   = 23'd1 << 18,
		S_WNEXT  = 23'd1 << 19,
		S_WCHK   = 23'd1 << 20,
		S_QRY    = 23'd1 << 21,
		S_RESP   = 23'd1 << 22
	} state_t;

	state_t   state_q, state_d;
	res_src_t src_q, src_d;
	stat_t    stat_q, stat_d;
	logic     out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		src_d   = src_q;
		stat_d  = stat_q;
		cmd.res_src  = src_q;
		cmd.res_stat = stat_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				src_d  = RS_ZERO;
				stat_d = ST_OK;
				if (sts.op == OP_OPEN) begin
					state_d = S_OPEN;
				end else if (sts.cnt_zero) begin
					stat_d  = ST_NOTOPEN;
					state_d = S_RESP;
				end else begin
					case (sts.op)
						OP_EVENT: begin
							if (sts.full) begin
								stat_d   = ST_FULL;
								cmd.shut = 1'b1;
								state_d  = S_RESP;
							end else begin
								cmd.ram_rd = 1'b1;
								cmd.rd_sel = RD_LAST;
								state_d    = S_LLD;
							end
						end
						OP_BLUR: begin
							if (sts.int_zero) begin
								stat_d        = ST_ZERO;
								cmd.sharp_clr = 1'b1;
								state_d       = S_RESP;
							end else begin
								state_d = S_NUM;
							end
						end
						default: begin
							cmd.ram_rd = 1'b1;
							cmd.rd_sel = RD_ZERO;
							state_d    = S_WLD0;
						end
					endcase
				end
			end
			S_OPEN: begin
				cmd.open = 1'b1;
				state_d  = S_RESP;
			end
			S_LLD: begin
				cmd.ent_load = 1'b1;
				state_d = sts.exposing ? S_EXX : S_APPEND;
			end
			S_EXX: begin
				cmd.x_load = 1'b1;
				state_d = S_EXLOG;
			end
			S_EXLOG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LOG;
				state_d = S_EXSPL;
			end
			S_EXSPL: begin
				cmd.split = 1'b1;
				state_d = S_EXP1;
			end
			S_EXP1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P1;
				state_d = S_EXP2;
			end
			S_EXP2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P2;
				state_d = S_EXP3;
			end
			S_EXP3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P3;
				state_d = S_EXFIN;
			end
			S_EXFIN: begin
				cmd.e_load = 1'b1;
				state_d = (sts.op == OP_EVENT) ? S_TERM : S_QRY;
			end
			S_TERM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_TERM;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.int_add = 1'b1;
				state_d = S_APPEND;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				cmd.shut   = 1'b1;
				state_d = S_RESP;
			end
			S_NUM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_NUM;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DIVFIN;
				end
			end
			S_DIVFIN: begin
				cmd.sharp_div = 1'b1;
				src_d   = RS_SHARP;
				state_d = S_RESP;
			end
			S_WLD0: begin
				cmd.ent_load = 1'b1;
				cmd.idx_clr  = 1'b1;
				state_d = S_WNEXT;
			end
			S_WNEXT: begin
				if (sts.walk_more) begin
					cmd.ram_rd = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d = S_WCHK;
				end else begin
					state_d = S_EXX;
				end
			end
			S_WCHK: begin
				if (sts.walk_hit) begin
					cmd.ent_load = 1'b1;
					cmd.idx_inc  = 1'b1;
					state_d = S_WNEXT;
				end else begin
					state_d = S_EXX;
				end
			end
			S_QRY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_QRY;
				src_d   = RS_QRY;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || m_tready) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, result tag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_q       <= RS_ZERO;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
			stat_q  <= stat_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/edip_dp.sv -----
// Datapath of the pixel engine: history RAM, shared multiplier, exp steps,
// integral, divider and result register. Depends on edip_pkg and edip_ram.
`default_nettype none

module edip_dp #(
	parameter int HISTORY_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	input  wire logic           cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic [119:0]   s_tdata,
	input  wire logic [1:0]     s_tuser,
	input  wire edip_pkg::cmd_t cmd,
	output edip_pkg::sts_t      sts,
	output logic      [31:0]    m_tdata,
	output logic      [1:0]     m_tuser
);
	import edip_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic        [14:0]         pos_con_q;
	logic signed [15:0]         neg_con_q;
	op_t                        op_q;
	logic        [TIME_W-1:0]   tm_q, t0_q, t1_q;
	logic        [1:0]          pr_q;
	logic        [15:0]         bv_q;
	logic        [CW-1:0]       cnt_q;
	logic        [INT_W-1:0]    integral_q;
	logic        [OUT_W-1:0]    sharp_q;
	logic                       exposing_q;
	logic        [TIME_W-1:0]   ent_time_q;
	logic        [CNT_W-1:0]    np_q, nn_q;
	logic        [AW-1:0]       idx_q;
	logic signed [23:0]         x_q;
	logic        [PROD_W-1:0]   prod_q;
	logic signed [12:0]         k_q;
	logic        [15:0]         f_q;
	logic        [OUT_W-1:0]    e_q;
	logic        [INT_W-1:0]    rem_q;
	logic        [DVD_W-1:0]    dvd_q;
	logic        [DIVC_W-1:0]   div_cnt_q;

	logic                       ram_we;
	logic        [AW-1:0]       waddr, raddr;
	logic        [ENTRY_W-1:0]  wdata, rdata;
	logic        [TIME_W-1:0]   rd_time;
	logic        [CNT_W-1:0]    rd_np, rd_nn, np_n, nn_n;
	logic        [TIME_W-1:0]   dt, dtw;
	logic signed [23:0]         xp, xn;
	logic signed [MUL_W-1:0]    ma, mb;
	logic signed [PROD_W-1:0]   mul_p;
	logic        [16:0]         tsum2, tsum3, p;
	logic        [4:0]          kneg;
	logic        [OUT_W-1:0]    e_n;
	logic        [INT_W:0]      trial, diff;
	logic                       ge;
	logic        [DVD_W:0]      isum;
	logic        [OUT_W-1:0]    qry_sat, div_sat;

	// History memory: {time, positive count, negative count}
	edip_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HISTORY_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.ram_rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_time = rdata[ENTRY_W-1:2*CNT_W];
	assign rd_np   = rdata[2*CNT_W-1:CNT_W];
	assign rd_nn   = rdata[CNT_W-1:0];

	// Next counts after the event
	assign np_n = (pr_q == POL_POS && np_q < COUNT_MAX) ? np_q + 1'b1 : np_q;
	assign nn_n = (pr_q[1] && nn_q < COUNT_MAX) ? nn_q + 1'b1 : nn_q;

	assign ram_we = cmd.open | cmd.append;
	assign waddr  = cmd.open ? '0 : cnt_q[AW-1:0];
	assign wdata  = cmd.open ? {tm_q, {(2*CNT_W){1'b0}}} : {tm_q, np_n, nn_n};

	// Read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_LAST: raddr = AW'(cnt_q - 1'b1);
			RD_ZERO: raddr = '0;
			default: raddr = idx_q + 1'b1;
		endcase
	end

	// Clamped time differences
	assign dt  = (tm_q >= ent_time_q) ? tm_q - ent_time_q : '0;
	assign dtw = (t1_q >= t0_q) ? t1_q - t0_q : '0;

	// Log-domain exponent
	assign xp = $signed({1'b0, pos_con_q}) * $signed({1'b0, np_q});
	assign xn = neg_con_q * $signed({1'b0, nn_q});

	// Polynomial partial sums from the previous product
	assign tsum2 = {1'b0, EXP_C2} + prod_q[32:16];
	assign tsum3 = {1'b0, EXP_C1} + prod_q[32:16];

	// Shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MS_LOG: begin
				ma = {{(MUL_W-24){x_q[23]}}, x_q};
				mb = {16'd0, LOG2E_Q16};
			end
			MS_P1: begin
				ma = {17'd0, f_q};
				mb = {17'd0, EXP_C3};
			end
			MS_P2: begin
				ma = {17'd0, f_q};
				mb = {16'd0, tsum2};
			end
			MS_P3: begin
				ma = {17'd0, f_q};
				mb = {16'd0, tsum3};
			end
			MS_TERM: begin
				ma = {1'b0, dt};
				mb = {1'b0, e_q};
			end
			MS_QRY: begin
				ma = {1'b0, e_q};
				mb = {1'b0, sharp_q};
			end
			MS_NUM: begin
				ma = {1'b0, dtw};
				mb = {17'd0, bv_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mul_p = ma * mb;

	// Scale 2^f by 2^k with range limits
	assign p    = 17'h10000 + prod_q[32:16];
	assign kneg = 5'(-k_q);
	always_comb begin
		if (k_q > 13'sd15) begin
			e_n = '1;
		end else if (k_q < -13'sd17) begin
			e_n = '0;
		end else if (!k_q[12]) begin
			e_n = OUT_W'(p) << k_q[3:0];
		end else begin
			e_n = OUT_W'(p >> kneg);
		end
	end

	// Integral add with saturation
	assign isum = {{(DVD_W-INT_W+1){1'b0}}, integral_q} + {1'b0, prod_q[63:8]};

	// Restoring divide step
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, integral_q};
	assign diff  = trial - {1'b0, integral_q};

	assign qry_sat = (|prod_q[63:48]) ? '1 : prod_q[47:16];
	assign div_sat = (|dvd_q[DVD_W-1:OUT_W]) ? '1 : dvd_q[OUT_W-1:0];

	// Configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_con_q  <= 15'd4096;
			neg_con_q  <= -16'sd4096;
			cnt_q      <= '0;
			integral_q <= '0;
			sharp_q    <= '0;
			exposing_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_POS_CONTRAST: pos_con_q <= cfg_data[14:0];
					default:          neg_con_q <= cfg_data;
				endcase
			end
			if (cmd.open) begin
				cnt_q      <= CW'(1);
				integral_q <= '0;
				sharp_q    <= '0;
				exposing_q <= 1'b1;
			end
			if (cmd.append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.shut && pr_q == POL_SHUTTER) begin
				exposing_q <= 1'b0;
			end
			if (cmd.int_add) begin
				integral_q <= (|isum[DVD_W:INT_W]) ? '1 : isum[INT_W-1:0];
			end
			if (cmd.sharp_clr) begin
				sharp_q <= '0;
			end
			if (cmd.sharp_div) begin
				sharp_q <= div_sat;
			end
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q <= op_t'(s_tuser);
			tm_q <= s_tdata[31:0];
			pr_q <= s_tdata[33:32];
			bv_q <= s_tdata[49:34];
			t0_q <= s_tdata[81:50];
			t1_q <= s_tdata[113:82];
		end
		if (cmd.ent_load) begin
			ent_time_q <= rd_time;
			np_q       <= rd_np;
			nn_q       <= rd_nn;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.x_load) begin
			x_q <= xp + xn;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.split) begin
			k_q <= prod_q[40:28];
			f_q <= prod_q[27:12];
		end
		if (cmd.e_load) begin
			e_q <= e_n;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= {prod_q[47:0], 8'd0};
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[INT_W-1:0] : trial[INT_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
		if (cmd.res_load) begin
			m_tuser <= cmd.res_stat;
			case (cmd.res_src)
				RS_SHARP: m_tdata <= sharp_q;
				RS_QRY:   m_tdata <= qry_sat;
				default:  m_tdata <= '0;
			endcase
		end
	end

	// Status to the controller
	always_comb begin
		sts.op        = op_q;
		sts.cnt_zero  = (cnt_q == '0);
		sts.full      = (cnt_q >= CW'(HISTORY_DEPTH));
		sts.int_zero  = (integral_q == '0);
		sts.exposing  = exposing_q;
		sts.walk_more = (CW'(idx_q) + CW'(1)) < cnt_q;
		sts.walk_hit  = (rd_time <= tm_q);
		sts.div_last  = (div_cnt_q == DIV_LAST);
	end

endmodule

`default_nettype wire

// ----- design/event_double_integral_pixel.sv -----
// Top level of the event double-integral pixel engine.
// Depends on edip_pkg, edip_ctrl, edip_dp (which holds edip_ram).
//
// One item is worked at a time; the result sits in an output register so the
// next item is taken while it waits. An event with an open exposure runs seven
// exp steps, four of them on the shared 33x33 multiplier, then the integral
// product and add; without one it only appends to the history. A full history,
// a zero integral or a pixel not yet opened answers with its status alone. A
// blurred value runs the 56-step restoring divider. A query steps past history
// entries one read at a time on the RAM's single registered read port, and
// stops at the end or on a later entry. Items after the pixel's first open see
// the history; before it all but open answer status 3. Configuration writes
// are always taken.
`default_nettype none

module event_double_integral_pixel #(
	parameter int HISTORY_DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// time_us[31:0], polarity[33:32], blurred_value[49:34],
	// window_start[81:50], window_end[113:82], zero fill
	input  wire logic [119:0] s_tdata,
	// op[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// intensity[31:0]
	output logic      [31:0]  m_tdata,
	// status[1:0]
	output logic      [1:0]   m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data
);
	import edip_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	edip_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	edip_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- design/edip_chk.sv -----
// Port-level checker for the pixel engine, bound to the top level.
// Depends on edip_pkg.
`default_nettype none

module edip_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [119:0] s_tdata,
	input wire logic [1:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [31:0]  m_tdata,
	input wire logic [1:0]   m_tuser,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready,
	input wire logic         cfg_index,
	input wire logic [15:0]  cfg_data
);
	import edip_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// Error results carry zero intensity
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata == '0)
		else $error("error result with nonzero intensity");

	// Configuration never stalls
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind event_double_integral_pixel edip_chk u_chk (.*);

`default_nettype wire
